>>> src/hics_pkg.sv
package hics_pkg;

    localparam int NUM_BINS = 256;
    // cumulative store address width and bin count / edge address width
    localparam int CW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int EW = $clog2(NUM_BINS + 1);

    localparam int CUM_W  = 40;
    localparam int QUOT_W = 32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_NRD,
        ST_NGO,
        ST_NDIV,
        ST_SRCH,
        ST_SCMP,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_CALC,
        ST_SDIV,
        ST_MUL,
        ST_FIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [CUM_W-1:0]  rem_init;
        logic [QUOT_W-1:0] low;
        logic [CUM_W-1:0]  divisor;
    } div_req_t;

endpackage

>>> src/hics_div.sv
module hics_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hics_pkg::div_req_t                 req,
    output logic                               done,
    output logic                               busy,
    output logic [hics_pkg::QUOT_W-1:0]        quot
);

    logic [hics_pkg::CUM_W-1:0]  rem_reg, rem_next;
    logic [hics_pkg::QUOT_W-1:0] low_reg, low_next;
    logic [hics_pkg::QUOT_W-1:0] q_reg, q_next;
    logic [hics_pkg::CUM_W-1:0]  div_reg, div_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [hics_pkg::CUM_W:0]    trial;
    logic [hics_pkg::CUM_W:0]    diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, low_reg[hics_pkg::QUOT_W-1]};
        diff      = trial - {1'b0, div_reg};
        if (req.start) begin
            rem_next  = req.rem_init;
            low_next  = req.low;
            div_next  = req.divisor;
            q_next    = '0;
            cnt_next  = '1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            low_next = {low_reg[hics_pkg::QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[hics_pkg::CUM_W-1:0];
                q_next   = {q_reg[hics_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                rem_next = trial[hics_pkg::CUM_W-1:0];
                q_next   = {q_reg[hics_pkg::QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign busy = busy_reg;
    assign quot = q_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without a running division");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while still busy");

endmodule

>>> src/histogram_inverse_cdf_sampler.sv
// histogram inverse-cdf sampler
// s_ channel: tuser = op (0 load bin, 1 draw sample), tlast = last bin of a load,
// tdata = bin_content, low_edge, high_edge, rnd (32 bits each, lowest first).
// m_ channel: tdata = sample_value (signed q16.16), tuser = empty_flag.
// a load transfer writes one bin; the last bin (tlast, or the bin count
// reaching NUM_BINS) then writes the upper edge and, if the total is not
// zero, normalizes every bin through the shared 32-step divider, one bin
// after another, while s_tready stays low.
// a sample transfer gives one result: binary search over the cumulative
// store (up to 8 probes for 256 bins), reads of the bin's cumulative values
// and edges, a division, a multiply and a fix-up; the division, multiply
// and fix-up are skipped when the bin is empty or the value sits at the bin's top.
// an empty or unfinished table answers 0 with empty_flag.
// the result waits in an output register, so a new transfer is taken while
// the receiver stalls; the block holds its last result until m_tready.
// reset clears the table state: samples then report empty until a load ends.
module histogram_inverse_cdf_sampler (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // bin_content, low_edge, high_edge, rnd
    input  logic         s_tuser,   // op
    input  logic         s_tlast,   // last_bin
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // sample_value
    output logic         m_tuser    // empty_flag
);

    localparam int CW = hics_pkg::CW;
    localparam int EW = hics_pkg::EW;

    logic [hics_pkg::CUM_W-1:0] cum_mem [hics_pkg::NUM_BINS];
    logic [31:0]                edge_mem [hics_pkg::NUM_BINS + 1];

    hics_pkg::state_t state_reg, state_next;
    logic [EW-1:0]    bins_reg, bins_next;
    logic [39:0]      total_reg, total_next;
    logic             ready_reg, ready_next;
    logic [EW-1:0]    nidx_reg, nidx_next;
    logic [CW-1:0]    lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [31:0]      r_reg, r_next;
    logic [39:0]      cur_reg, cur_next, base_reg, base_next;
    logic [31:0]      elo_reg, elo_next, ehi_reg, ehi_next;
    logic [31:0]      f_reg, f_next;
    logic [64:0]      prod_reg, prod_next;
    logic             wneg_reg, wneg_next;
    logic [31:0]      res_reg, res_next;
    logic             flag_reg, flag_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg, m_data_next;
    logic             m_user_reg, m_user_next;

    logic             cum_we;
    logic [CW-1:0]    cum_waddr, cum_raddr;
    logic [39:0]      cum_wdata, cum_q_reg;
    logic             edge_we;
    logic [EW-1:0]    edge_waddr, edge_raddr;
    logic [31:0]      edge_wdata, edge_q_reg;

    hics_pkg::div_req_t dreq;
    logic               div_done, div_busy;
    logic [31:0]        div_quot;

    logic [31:0] in_content, in_low, in_high, in_rnd;
    logic [CW-1:0] lidx;
    logic [EW-1:0] cnt1;
    logic [39:0] lbase;
    logic [40:0] lsum;
    logic [71:0] nprod;
    logic [CW:0] midsum;
    logic [39:0] dval, r40, rb;
    logic [32:0] spair, wd, mag;
    logic [32:0] whole;

    assign in_content = s_tdata[31:0];
    assign in_low     = s_tdata[63:32];
    assign in_high    = s_tdata[95:64];
    assign in_rnd     = s_tdata[127:96];

    always_ff @(posedge aclk) begin
        if (cum_we) begin
            cum_mem[cum_waddr] <= cum_wdata;
        end
        cum_q_reg <= cum_mem[cum_raddr];
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_q_reg <= edge_mem[edge_raddr];
    end

    hics_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .done    (div_done),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    always_comb begin
        state_next   = state_reg;
        bins_next    = bins_reg;
        total_next   = total_reg;
        ready_next   = ready_reg;
        nidx_next    = nidx_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        r_next       = r_reg;
        cur_next     = cur_reg;
        base_next    = base_reg;
        elo_next     = elo_reg;
        ehi_next     = ehi_reg;
        f_next       = f_reg;
        prod_next    = prod_reg;
        wneg_next    = wneg_reg;
        res_next     = res_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        s_tready     = 1'b0;
        cum_we       = 1'b0;
        cum_waddr    = '0;
        cum_wdata    = '0;
        cum_raddr    = '0;
        edge_we      = 1'b0;
        edge_waddr   = '0;
        edge_wdata   = '0;
        edge_raddr   = '0;
        dreq         = '0;

        lidx   = ready_reg ? '0 : bins_reg[CW-1:0];
        cnt1   = EW'(lidx) + EW'(1);
        lbase  = ready_reg ? '0 : total_reg;
        lsum   = {1'b0, lbase} + (in_content[31] ? 41'd0 : {9'd0, in_content});
        nprod  = {cum_q_reg, 32'd0} - {32'd0, cum_q_reg};
        midsum = {1'b0, lo_reg} + {1'b0, hi_reg};
        dval   = cur_reg - base_reg;
        r40    = {8'd0, r_reg};
        rb     = (r40 < base_reg) ? '0 : r40 - base_reg;
        spair  = {elo_reg[31], elo_reg} + {ehi_reg[31], ehi_reg};
        wd     = {ehi_reg[31], ehi_reg} - {elo_reg[31], elo_reg};
        mag    = wd[32] ? (33'd0 - wd) : wd;
        whole  = prod_reg[64:32] + {32'd0, wneg_reg && (prod_reg[31:0] != 32'd0)};

        case (state_reg)
            hics_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == hics_pkg::OP_LOAD) begin
                        total_next = lsum[40] ? '1 : lsum[39:0];
                        cum_we     = 1'b1;
                        cum_waddr  = lidx;
                        cum_wdata  = total_next;
                        edge_we    = 1'b1;
                        edge_waddr = EW'(lidx);
                        edge_wdata = in_low;
                        bins_next  = cnt1;
                        ready_next = 1'b0;
                        if (s_tlast || cnt1 == EW'(hics_pkg::NUM_BINS)) begin
                            ehi_next   = in_high;
                            state_next = hics_pkg::ST_EDGE;
                        end
                    end else begin
                        r_next = in_rnd;
                        if (!ready_reg || total_reg == '0) begin
                            res_next   = '0;
                            flag_next  = 1'b1;
                            state_next = hics_pkg::ST_OUT;
                        end else begin
                            lo_next    = '0;
                            hi_next    = CW'(bins_reg - EW'(1));
                            state_next = hics_pkg::ST_SRCH;
                        end
                    end
                end
            end
            hics_pkg::ST_EDGE: begin
                edge_we    = 1'b1;
                edge_waddr = bins_reg;
                edge_wdata = ehi_reg;
                nidx_next  = '0;
                if (total_reg == '0) begin
                    ready_next = 1'b1;
                    state_next = hics_pkg::ST_IDLE;
                end else begin
                    state_next = hics_pkg::ST_NRD;
                end
            end
            hics_pkg::ST_NRD: begin
                cum_raddr  = nidx_reg[CW-1:0];
                state_next = hics_pkg::ST_NGO;
            end
            hics_pkg::ST_NGO: begin
                // cum * (2^32-1) / total
                dreq.start    = 1'b1;
                dreq.rem_init = nprod[71:32];
                dreq.low      = nprod[31:0];
                dreq.divisor  = total_reg;
                state_next    = hics_pkg::ST_NDIV;
            end
            hics_pkg::ST_NDIV: begin
                if (div_done) begin
                    cum_we    = 1'b1;
                    cum_waddr = nidx_reg[CW-1:0];
                    cum_wdata = {8'd0, div_quot};
                    nidx_next = nidx_reg + EW'(1);
                    if (nidx_next == bins_reg) begin
                        ready_next = 1'b1;
                        state_next = hics_pkg::ST_IDLE;
                    end else begin
                        state_next = hics_pkg::ST_NRD;
                    end
                end
            end
            hics_pkg::ST_SRCH: begin
                if (lo_reg == hi_reg) begin
                    state_next = hics_pkg::ST_F0;
                end else begin
                    mid_next   = midsum[CW:1];
                    cum_raddr  = midsum[CW:1];
                    state_next = hics_pkg::ST_SCMP;
                end
            end
            hics_pkg::ST_SCMP: begin
                if (cum_q_reg > r40) begin
                    hi_next = mid_reg;
                end else begin
                    lo_next = mid_reg + CW'(1);
                end
                state_next = hics_pkg::ST_SRCH;
            end
            hics_pkg::ST_F0: begin
                cum_raddr  = lo_reg;
                edge_raddr = EW'(lo_reg);
                state_next = hics_pkg::ST_F1;
            end
            hics_pkg::ST_F1: begin
                cur_next   = cum_q_reg;
                elo_next   = edge_q_reg;
                cum_raddr  = lo_reg - CW'(1);
                edge_raddr = EW'(lo_reg) + EW'(1);
                state_next = hics_pkg::ST_F2;
            end
            hics_pkg::ST_F2: begin
                base_next  = (lo_reg == '0) ? '0 : cum_q_reg;
                ehi_next   = edge_q_reg;
                state_next = hics_pkg::ST_CALC;
            end
            hics_pkg::ST_CALC: begin
                flag_next = 1'b0;
                if (dval == '0) begin
                    // empty bin: floor of the midpoint
                    res_next   = spair[32:1];
                    state_next = hics_pkg::ST_OUT;
                end else if (rb >= dval) begin
                    res_next   = ehi_reg;
                    state_next = hics_pkg::ST_OUT;
                end else begin
                    dreq.start    = 1'b1;
                    dreq.rem_init = rb;
                    dreq.low      = '0;
                    dreq.divisor  = dval;
                    state_next    = hics_pkg::ST_SDIV;
                end
            end
            hics_pkg::ST_SDIV: begin
                if (div_done) begin
                    f_next     = div_quot;
                    state_next = hics_pkg::ST_MUL;
                end
            end
            hics_pkg::ST_MUL: begin
                prod_next  = mag * {1'b0, f_reg};
                wneg_next  = wd[32];
                state_next = hics_pkg::ST_FIX;
            end
            hics_pkg::ST_FIX: begin
                // negative width rounds the offset toward minus infinity
                res_next   = wneg_reg ? elo_reg - whole[31:0] : elo_reg + whole[31:0];
                state_next = hics_pkg::ST_OUT;
            end
            hics_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_user_next  = flag_reg;
                    state_next   = hics_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hics_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        nidx_reg   <= nidx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        r_reg      <= r_next;
        cur_reg    <= cur_next;
        base_reg   <= base_next;
        elo_reg    <= elo_next;
        ehi_reg    <= ehi_next;
        f_reg      <= f_next;
        prod_reg   <= prod_next;
        wneg_reg   <= wneg_next;
        res_reg    <= res_next;
        flag_reg   <= flag_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        if (!aresetn) begin
            state_reg   <= hics_pkg::ST_IDLE;
            bins_reg    <= '0;
            total_reg   <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bins_reg    <= bins_next;
            total_reg   <= total_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_ready_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> bins_reg != '0) else $error("finished table with no bins");
    a_search_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == hics_pkg::ST_SCMP |-> mid_reg < hi_reg && lo_reg <= mid_reg)
        else $error("search probe out of range");
    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == hics_pkg::ST_SRCH |-> lo_reg <= hi_reg && hi_reg < bins_reg)
        else $error("search bounds crossed");
    a_norm_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == hics_pkg::ST_NDIV |-> nidx_reg < bins_reg)
        else $error("normalization index past loaded bins");
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hics_pkg::ST_NGO || state_reg == hics_pkg::ST_CALC) |-> !div_busy)
        else $error("divider busy at a new division");

endmodule
